[hdl/hid_report_descriptor_parser_assert.svh]
// Assertion macros shared by the descriptor parser modules
`ifndef HID_REPORT_DESCRIPTOR_PARSER_ASSERT_SVH
`define HID_REPORT_DESCRIPTOR_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define HRDP_ASSERT_IMPL(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("hrdp: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define HRDP_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("hrdp: next-cycle check failed");

`endif

[hdl/hrdp_pkg.sv]
// Types, item codes and helper functions of the HID report descriptor parser
package hrdp_pkg;

    // result queue depth, room for at least two items in flight
    localparam int unsigned RQ_DEPTH = 8;

    // item types
    localparam logic [1:0] ITEM_MAIN   = 2'd0;
    localparam logic [1:0] ITEM_GLOBAL = 2'd1;
    localparam logic [1:0] ITEM_LOCAL  = 2'd2;

    // main item tags
    localparam logic [3:0] TAG_INPUT      = 4'd8;
    localparam logic [3:0] TAG_COLLECTION = 4'd10;
    localparam logic [3:0] TAG_END_COLL   = 4'd12;

    // global item tags
    localparam logic [3:0] TAG_USAGE_PAGE   = 4'd0;
    localparam logic [3:0] TAG_LOGICAL_MIN  = 4'd1;
    localparam logic [3:0] TAG_LOGICAL_MAX  = 4'd2;
    localparam logic [3:0] TAG_REPORT_SIZE  = 4'd7;
    localparam logic [3:0] TAG_REPORT_ID    = 4'd8;
    localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;

    // local item tags
    localparam logic [3:0] TAG_USAGE     = 4'd0;
    localparam logic [3:0] TAG_USAGE_MIN = 4'd1;
    localparam logic [3:0] TAG_USAGE_MAX = 4'd2;

    localparam logic [3:0] TAG_LONG = 4'd15;

    // result kinds
    localparam logic [2:0] KIND_USAGES   = 3'd0;
    localparam logic [2:0] KIND_BITFIELD = 3'd1;
    localparam logic [2:0] KIND_ARRAY    = 3'd2;
    localparam logic [2:0] KIND_UNMAPPED = 3'd3;
    localparam logic [2:0] KIND_DONE_OK  = 3'd4;
    localparam logic [2:0] KIND_DONE_ERR = 3'd5;

    localparam logic [15:0] PAGE_GENERIC_DESKTOP = 16'd1;
    localparam logic [15:0] USAGE_MOUSE          = 16'd2;
    localparam logic [15:0] USAGE_JOYSTICK       = 16'd4;
    localparam logic [15:0] USAGE_GAMEPAD        = 16'd5;
    localparam logic [15:0] USAGE_KEYBOARD       = 16'd6;
    localparam logic [31:0] COLL_APPLICATION     = 32'd1;
    localparam logic [15:0] USAGE_UNSET          = 16'hFFFF;

    // accepted byte handed from the assembler to the executor, flagged when it completes an item
    typedef struct packed {
        logic        valid;
        logic        last;
        logic        complete;
        logic [7:0]  prefix;
        logic [31:0] data;
    } t_item;

    typedef struct packed {
        logic [2:0]         result_kind;
        logic [15:0]        start_bit;
        logic [15:0]        field_size;
        logic [15:0]        field_count;
        logic [7:0]         report_ident;
        logic [15:0]        app_usage;
        logic [15:0]        usage_low;
        logic [15:0]        usage_high;
        logic [4:0]         usage_count;
        logic signed [31:0] logical_low;
        logic signed [31:0] logical_high;
        logic               new_report;
    } t_result;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    // number of data bytes, size code 3 means four
    function automatic logic [2:0] data_len(input logic [7:0] prefix);
        logic [2:0] len;
        len = (prefix[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix[1:0]};
        return len;
    endfunction

    // data is already zero above its length; extend the sign of short data
    function automatic logic [31:0] sign_data(input logic [2:0] len, input logic [31:0] data);
        logic [31:0] v;
        v = data;
        if (len == 3'd1 && data[7]) begin
            v = {24'hFFFFFF, data[7:0]};
        end else if (len == 3'd2 && data[15]) begin
            v = {16'hFFFF, data[15:0]};
        end
        return v;
    endfunction

endpackage

[hdl/hrdp_in_if.sv]
// Descriptor byte channel
interface hrdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] desc_byte;
    logic       last_byte;

    modport source (output valid, output desc_byte, output last_byte, input ready);
    modport sink   (input valid, input desc_byte, input last_byte, output ready);
endinterface

[hdl/hrdp_out_if.sv]
// Decoded result channel
interface hrdp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         result_kind;
    logic [15:0]        start_bit;
    logic [15:0]        field_size;
    logic [15:0]        field_count;
    logic [7:0]         report_ident;
    logic [15:0]        app_usage;
    logic [15:0]        usage_low;
    logic [15:0]        usage_high;
    logic [4:0]         usage_count;
    logic signed [31:0] logical_low;
    logic signed [31:0] logical_high;
    logic               new_report;

    modport source (
        output valid, output result_kind, output start_bit, output field_size,
        output field_count, output report_ident, output app_usage, output usage_low,
        output usage_high, output usage_count, output logical_low, output logical_high,
        output new_report, input ready
    );
    modport sink (
        input valid, input result_kind, input start_bit, input field_size,
        input field_count, input report_ident, input app_usage, input usage_low,
        input usage_high, input usage_count, input logical_low, input logical_high,
        input new_report, output ready
    );
endinterface

[hdl/hrdp_byte_asm.sv]
// Input register and short-item byte assembly (prefix, data bytes, long-item error)
`include "hid_report_descriptor_parser_assert.svh"
module hrdp_byte_asm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hrdp_in_if.sink        i_desc,
    input  logic           i_room,
    output hrdp_pkg::t_item o_item
);

    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [2:0]  r_phase;
    logic [7:0]  r_prefix;
    logic [31:0] r_accum;
    logic        r_error;

    logic [2:0]  n_phase;
    logic [7:0]  n_prefix;
    logic [31:0] n_accum;
    logic        n_error;
    logic        complete;
    logic [2:0]  byte_idx;

    assign i_desc.ready = i_room;

    always_comb begin
        n_phase  = r_phase;
        n_prefix = r_prefix;
        n_accum  = r_accum;
        n_error  = r_error;
        complete = 1'b0;
        byte_idx = hrdp_pkg::data_len(r_prefix) - r_phase;
        if (r_valid && !r_error) begin
            if (r_phase == 3'd0) begin
                n_prefix = r_byte;
                n_accum  = '0;
                if (r_byte[7:4] == hrdp_pkg::TAG_LONG) begin
                    n_error = 1'b1;
                end else begin
                    n_phase  = hrdp_pkg::data_len(r_byte);
                    complete = (n_phase == 3'd0);
                end
            end else begin
                // little-endian: byte k of the data lands at bits 8k+7..8k
                n_accum  = r_accum | ({24'd0, r_byte} << {byte_idx[1:0], 3'b000});
                n_phase  = r_phase - 3'd1;
                complete = (n_phase == 3'd0);
            end
        end
    end

    assign o_item.valid    = r_valid;
    assign o_item.last     = r_last;
    assign o_item.complete = complete;
    assign o_item.prefix   = n_prefix;
    assign o_item.data     = n_accum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_phase  <= '0;
            r_prefix <= '0;
            r_accum  <= '0;
            r_error  <= 1'b0;
        end else begin
            r_valid <= i_desc.valid && i_desc.ready;
            if (r_valid && r_last) begin
                r_phase  <= '0;
                r_prefix <= '0;
                r_accum  <= '0;
                r_error  <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_prefix <= n_prefix;
                r_accum  <= n_accum;
                r_error  <= n_error;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_desc.valid && i_desc.ready) begin
            r_byte <= i_desc.desc_byte;
            r_last <= i_desc.last_byte;
        end
    end

    `HRDP_ASSERT_IMPL(a_error_no_phase, i_clk, i_rst_n, r_error, r_phase == 3'd0)
    `HRDP_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, r_valid && r_last, r_phase == 3'd0 && !r_error)

endmodule

[hdl/hrdp_item_exec.sv]
// Item execution: global, local and collection state, segment and done results
`include "hid_report_descriptor_parser_assert.svh"
module hrdp_item_exec #(
    parameter int MAX_USAGES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hrdp_pkg::t_item i_item,
    output hrdp_pkg::t_push o_push
);

    localparam int CNT_W = $clog2(MAX_USAGES + 1);

    logic [15:0]      r_usage_page, n_usage_page;
    logic [15:0]      r_size, n_size;
    logic [15:0]      r_count, n_count;
    logic [7:0]       r_ident, n_ident;
    logic [31:0]      r_log_min, n_log_min;
    logic [31:0]      r_log_max, n_log_max;
    logic [15:0]      r_local_usage, n_local_usage;
    logic [15:0]      r_local_min, n_local_min;
    logic [15:0]      r_local_max, n_local_max;
    logic [CNT_W-1:0] r_local_cnt, n_local_cnt;
    logic [15:0]      r_app_usage, n_app_usage;
    logic [15:0]      r_app_page, n_app_page;
    logic [7:0]       r_nest, n_nest;
    logic [15:0]      r_bit_offset, n_bit_offset;
    logic             r_report_open, n_report_open;

    logic [1:0]       item_type;
    logic [3:0]       item_tag;
    logic [2:0]       item_len;
    logic [31:0]      sdata;
    logic [31:0]      seg_bits;
    logic             in_app;
    logic             seg_fire;
    logic [2:0]       seg_kind;
    logic             run;
    hrdp_pkg::t_result seg_res;
    hrdp_pkg::t_result done_res;

    assign item_type = i_item.prefix[3:2];
    assign item_tag  = i_item.prefix[7:4];
    assign item_len  = hrdp_pkg::data_len(i_item.prefix);
    assign sdata     = hrdp_pkg::sign_data(item_len, i_item.data);
    assign seg_bits  = 32'(r_size) * 32'(r_count);
    assign run       = i_item.valid && i_item.complete;

    assign in_app = (r_app_page == hrdp_pkg::PAGE_GENERIC_DESKTOP) &&
                    (r_app_usage inside {hrdp_pkg::USAGE_MOUSE, hrdp_pkg::USAGE_JOYSTICK,
                                         hrdp_pkg::USAGE_GAMEPAD, hrdp_pkg::USAGE_KEYBOARD});
    assign seg_fire = run && item_type == hrdp_pkg::ITEM_MAIN &&
                      item_tag == hrdp_pkg::TAG_INPUT && in_app;

    // data bit 1 set means a variable field
    always_comb begin
        if (!i_item.data[1]) begin
            seg_kind = hrdp_pkg::KIND_ARRAY;
        end else if (r_local_cnt != '0) begin
            seg_kind = hrdp_pkg::KIND_USAGES;
        end else if (r_local_min != hrdp_pkg::USAGE_UNSET &&
                     r_local_max != hrdp_pkg::USAGE_UNSET && r_size == 16'd1) begin
            seg_kind = hrdp_pkg::KIND_BITFIELD;
        end else begin
            seg_kind = hrdp_pkg::KIND_UNMAPPED;
        end
    end

    always_comb begin
        seg_res.result_kind  = seg_kind;
        seg_res.start_bit    = r_bit_offset;
        seg_res.field_size   = r_size;
        seg_res.field_count  = r_count;
        seg_res.report_ident = r_ident;
        seg_res.app_usage    = r_app_usage;
        seg_res.usage_low    = r_local_min;
        seg_res.usage_high   = r_local_max;
        seg_res.usage_count  = 5'(r_local_cnt);
        seg_res.logical_low  = r_log_min;
        seg_res.logical_high = r_log_max;
        seg_res.new_report   = !r_report_open;

        done_res             = '0;
        done_res.result_kind = i_item.complete ? hrdp_pkg::KIND_DONE_OK
                                               : hrdp_pkg::KIND_DONE_ERR;

        o_push.first  = seg_fire ? seg_res : done_res;
        o_push.second = done_res;
        if (i_item.valid && i_item.last) begin
            o_push.count = seg_fire ? 2'd2 : 2'd1;
        end else begin
            o_push.count = seg_fire ? 2'd1 : 2'd0;
        end
    end

    always_comb begin
        n_usage_page  = r_usage_page;
        n_size        = r_size;
        n_count       = r_count;
        n_ident       = r_ident;
        n_log_min     = r_log_min;
        n_log_max     = r_log_max;
        n_local_usage = r_local_usage;
        n_local_min   = r_local_min;
        n_local_max   = r_local_max;
        n_local_cnt   = r_local_cnt;
        n_app_usage   = r_app_usage;
        n_app_page    = r_app_page;
        n_nest        = r_nest;
        n_bit_offset  = r_bit_offset;
        n_report_open = r_report_open;
        if (run) begin
            case (item_type)
                hrdp_pkg::ITEM_MAIN: begin
                    case (item_tag)
                        hrdp_pkg::TAG_INPUT: begin
                            if (seg_fire) begin
                                n_report_open = 1'b1;
                            end
                            n_bit_offset = r_bit_offset + seg_bits[15:0];
                        end
                        hrdp_pkg::TAG_COLLECTION: begin
                            n_nest = r_nest + 8'd1;
                            if (i_item.data == hrdp_pkg::COLL_APPLICATION) begin
                                n_app_usage = r_local_usage;
                                n_app_page  = r_usage_page;
                            end
                        end
                        hrdp_pkg::TAG_END_COLL: begin
                            n_nest = r_nest - 8'd1;
                            if (n_nest == 8'd0) begin
                                n_app_usage = '0;
                                n_app_page  = '0;
                            end
                        end
                        default: ;
                    endcase
                    // every main item ends the local scope
                    n_local_usage = '0;
                    n_local_min   = hrdp_pkg::USAGE_UNSET;
                    n_local_max   = hrdp_pkg::USAGE_UNSET;
                    n_local_cnt   = '0;
                end
                hrdp_pkg::ITEM_GLOBAL: begin
                    case (item_tag)
                        hrdp_pkg::TAG_USAGE_PAGE:   n_usage_page = i_item.data[15:0];
                        hrdp_pkg::TAG_LOGICAL_MIN:  n_log_min = sdata;
                        hrdp_pkg::TAG_LOGICAL_MAX:  n_log_max = r_log_min[31] ? sdata : i_item.data;
                        hrdp_pkg::TAG_REPORT_SIZE:  n_size = i_item.data[15:0];
                        hrdp_pkg::TAG_REPORT_ID: begin
                            n_bit_offset  = {10'd0, item_len, 3'b000};
                            n_ident       = i_item.data[7:0];
                            n_report_open = 1'b0;
                        end
                        hrdp_pkg::TAG_REPORT_COUNT: n_count = i_item.data[15:0];
                        default: ;
                    endcase
                end
                hrdp_pkg::ITEM_LOCAL: begin
                    case (item_tag)
                        hrdp_pkg::TAG_USAGE: begin
                            n_local_usage = i_item.data[15:0];
                            if (r_local_cnt < CNT_W'(MAX_USAGES)) begin
                                n_local_cnt = r_local_cnt + CNT_W'(1);
                            end
                        end
                        hrdp_pkg::TAG_USAGE_MIN: n_local_min = i_item.data[15:0];
                        hrdp_pkg::TAG_USAGE_MAX: n_local_max = i_item.data[15:0];
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_item.valid && i_item.last)) begin
            r_usage_page  <= '0;
            r_size        <= '0;
            r_count       <= '0;
            r_ident       <= '0;
            r_log_min     <= '0;
            r_log_max     <= '0;
            r_local_usage <= '0;
            r_local_min   <= hrdp_pkg::USAGE_UNSET;
            r_local_max   <= hrdp_pkg::USAGE_UNSET;
            r_local_cnt   <= '0;
            r_app_usage   <= '0;
            r_app_page    <= '0;
            r_nest        <= '0;
            r_bit_offset  <= '0;
            r_report_open <= 1'b0;
        end else begin
            r_usage_page  <= n_usage_page;
            r_size        <= n_size;
            r_count       <= n_count;
            r_ident       <= n_ident;
            r_log_min     <= n_log_min;
            r_log_max     <= n_log_max;
            r_local_usage <= n_local_usage;
            r_local_min   <= n_local_min;
            r_local_max   <= n_local_max;
            r_local_cnt   <= n_local_cnt;
            r_app_usage   <= n_app_usage;
            r_app_page    <= n_app_page;
            r_nest        <= n_nest;
            r_bit_offset  <= n_bit_offset;
            r_report_open <= n_report_open;
        end
    end

    `HRDP_ASSERT_NEXT(a_last_resets, i_clk, i_rst_n, i_item.valid && i_item.last, r_nest == 8'd0 && r_bit_offset == 16'd0 && r_local_cnt == '0)
    `HRDP_ASSERT_IMPL(a_two_only_last, i_clk, i_rst_n, o_push.count == 2'd2, i_item.valid && i_item.last && seg_fire)

endmodule

[hdl/hrdp_result_queue.sv]
// Result queue: takes up to two results a cycle, hands out one per beat
`include "hid_report_descriptor_parser_assert.svh"
module hrdp_result_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hrdp_pkg::t_push i_push,
    input  logic            i_inflight,
    output logic            o_room,
    hrdp_out_if.source      o_res
);

    localparam int DEPTH = hrdp_pkg::RQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hrdp_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_count;

    logic              pop;
    logic [PTR_W-1:0]  tail_plus1;
    logic [CNT_W:0]    need;
    hrdp_pkg::t_result head;

    assign pop        = (r_count != '0) && o_res.ready;
    assign tail_plus1 = r_tail + PTR_W'(1);

    // a new byte may need two slots, on top of two for the byte now executing
    assign need   = {1'b0, r_count} + (i_inflight ? (CNT_W+1)'(2) : '0) + (CNT_W+1)'(2);
    assign o_room = need <= (CNT_W+1)'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + PTR_W'(i_push.count);
            r_count <= r_count + CNT_W'(i_push.count) - CNT_W'(pop);
            if (pop) begin
                r_head <= r_head + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[tail_plus1] <= i_push.second;
        end
    end

    assign head = r_mem[r_head];

    assign o_res.valid        = r_count != '0;
    assign o_res.result_kind  = head.result_kind;
    assign o_res.start_bit    = head.start_bit;
    assign o_res.field_size   = head.field_size;
    assign o_res.field_count  = head.field_count;
    assign o_res.report_ident = head.report_ident;
    assign o_res.app_usage    = head.app_usage;
    assign o_res.usage_low    = head.usage_low;
    assign o_res.usage_high   = head.usage_high;
    assign o_res.usage_count  = head.usage_count;
    assign o_res.logical_low  = head.logical_low;
    assign o_res.logical_high = head.logical_high;
    assign o_res.new_report   = head.new_report;

    `HRDP_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push.count != 2'd0, ({1'b0, r_count} + (CNT_W+1)'(i_push.count)) <= (CNT_W+1)'(DEPTH))
    `HRDP_ASSERT_NEXT(a_head_holds, i_clk, i_rst_n, o_res.valid && !o_res.ready, $stable(r_head))

endmodule

[hdl/hid_report_descriptor_parser.sv]
// Results: a byte is held in the input register, decoded from it straight into the
// result queue and offered from there; its second result follows the first.
// Throughput: one descriptor byte per cycle; input stalls only while the
// 8-entry result queue lacks room for two results per byte in flight.
// Reset: synchronous, active low, clears all parse state and the queue;
// a byte flagged last returns the parse state to its reset values.
module hid_report_descriptor_parser #(
    parameter int MAX_USAGES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrdp_in_if.sink    i_desc,
    hrdp_out_if.source o_res
);

    hrdp_pkg::t_item item;
    hrdp_pkg::t_push push;
    logic            room;

    hrdp_byte_asm u_byte_asm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_desc  (i_desc),
        .i_room  (room),
        .o_item  (item)
    );

    hrdp_item_exec #(
        .MAX_USAGES (MAX_USAGES)
    ) u_item_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .o_push  (push)
    );

    hrdp_result_queue u_result_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_inflight (item.valid),
        .o_room     (room),
        .o_res      (o_res)
    );

endmodule

[bench/testbench.sv]
// Self-checking bench for the HID report descriptor parser: directed and random descriptors
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned USAGE_LIMIT    = 16;
    localparam logic [3:0]  TAG_OUTPUT     = 4'd9;
    localparam logic [3:0]  TAG_FEATURE    = 4'd11;
    localparam logic [31:0] INPUT_VARIABLE = 32'h2;
    localparam logic [31:0] INPUT_RELATIVE = 32'h4;
    localparam logic [31:0] COLL_PHYSICAL  = 32'd0;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hrdp_in_if  desc_if ();
    hrdp_out_if res_if ();

    hid_report_descriptor_parser #(
        .MAX_USAGES(USAGE_LIMIT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_desc (desc_if),
        .o_res  (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------- decoder state mirror ----------------
    logic [2:0]  bytes_left;
    logic [7:0]  cur_prefix;
    logic [31:0] data_word;
    logic [15:0] g_page;
    logic [15:0] g_size;
    logic [15:0] g_count;
    logic [7:0]  g_report_id;
    logic [31:0] g_logical_min;
    logic [31:0] g_logical_max;
    logic [15:0] l_usage;
    logic [15:0] l_usage_min;
    logic [15:0] l_usage_max;
    int unsigned l_usage_count;
    logic [15:0] app_usage_q;
    logic [15:0] app_page_q;
    logic [7:0]  depth;
    logic [15:0] bit_pos;
    logic        report_live;
    logic        long_seen;

    hrdp_pkg::t_result awaited_results[$];
    logic [7:0]  desc_q[$];
    int          bad_results = 0;
    bit          sender_idles = 1'b0;
    bit          sink_stalls = 1'b0;
    int          stall_left = 0;

    function automatic void clear_locals();
        l_usage       = '0;
        l_usage_min   = hrdp_pkg::USAGE_UNSET;
        l_usage_max   = hrdp_pkg::USAGE_UNSET;
        l_usage_count = 0;
    endfunction

    function automatic void reset_parse();
        bytes_left    = '0;
        cur_prefix    = '0;
        data_word     = '0;
        g_page        = '0;
        g_size        = '0;
        g_count       = '0;
        g_report_id   = '0;
        g_logical_min = '0;
        g_logical_max = '0;
        clear_locals();
        app_usage_q   = '0;
        app_page_q    = '0;
        depth         = '0;
        bit_pos       = '0;
        report_live   = 1'b0;
        long_seen     = 1'b0;
    endfunction

    // act on a completed short item
    function automatic void run_decoded_item();
        logic [1:0]  item_type;
        logic [3:0]  item_tag;
        int unsigned nbytes;
        logic [31:0] sval;
        hrdp_pkg::t_result seg;
        item_type = cur_prefix[3:2];
        item_tag  = cur_prefix[7:4];
        nbytes    = (cur_prefix[1:0] == 2'd3) ? 4 : cur_prefix[1:0];
        sval      = data_word;
        if (nbytes == 1 && data_word[7]) begin
            sval = {24'hFFFFFF, data_word[7:0]};
        end else if (nbytes == 2 && data_word[15]) begin
            sval = {16'hFFFF, data_word[15:0]};
        end
        case (item_type)
            hrdp_pkg::ITEM_MAIN: begin
                if (item_tag == hrdp_pkg::TAG_INPUT) begin
                    if (app_page_q == hrdp_pkg::PAGE_GENERIC_DESKTOP &&
                        (app_usage_q == hrdp_pkg::USAGE_MOUSE ||
                         app_usage_q == hrdp_pkg::USAGE_JOYSTICK ||
                         app_usage_q == hrdp_pkg::USAGE_GAMEPAD ||
                         app_usage_q == hrdp_pkg::USAGE_KEYBOARD)) begin
                        seg = '0;
                        if (data_word[1]) begin
                            if (l_usage_count != 0) begin
                                seg.result_kind = hrdp_pkg::KIND_USAGES;
                            end else if (l_usage_min != hrdp_pkg::USAGE_UNSET &&
                                         l_usage_max != hrdp_pkg::USAGE_UNSET &&
                                         g_size == 16'd1) begin
                                seg.result_kind = hrdp_pkg::KIND_BITFIELD;
                            end else begin
                                seg.result_kind = hrdp_pkg::KIND_UNMAPPED;
                            end
                        end else begin
                            seg.result_kind = hrdp_pkg::KIND_ARRAY;
                        end
                        seg.start_bit    = bit_pos;
                        seg.field_size   = g_size;
                        seg.field_count  = g_count;
                        seg.report_ident = g_report_id;
                        seg.app_usage    = app_usage_q;
                        seg.usage_low    = l_usage_min;
                        seg.usage_high   = l_usage_max;
                        seg.usage_count  = l_usage_count[4:0];
                        seg.logical_low  = g_logical_min;
                        seg.logical_high = g_logical_max;
                        seg.new_report   = !report_live;
                        report_live      = 1'b1;
                        awaited_results.push_back(seg);
                    end
                    bit_pos = bit_pos + g_size * g_count;
                end else if (item_tag == hrdp_pkg::TAG_COLLECTION) begin
                    depth = depth + 8'd1;
                    if (data_word == hrdp_pkg::COLL_APPLICATION) begin
                        app_usage_q = l_usage;
                        app_page_q  = g_page;
                    end
                end else if (item_tag == hrdp_pkg::TAG_END_COLL) begin
                    depth = depth - 8'd1;
                    if (depth == 8'd0) begin
                        app_usage_q = '0;
                        app_page_q  = '0;
                    end
                end
                clear_locals();
            end
            hrdp_pkg::ITEM_GLOBAL: begin
                case (item_tag)
                    hrdp_pkg::TAG_USAGE_PAGE:   g_page = data_word[15:0];
                    hrdp_pkg::TAG_LOGICAL_MIN:  g_logical_min = sval;
                    hrdp_pkg::TAG_LOGICAL_MAX:
                        g_logical_max = g_logical_min[31] ? sval : data_word;
                    hrdp_pkg::TAG_REPORT_SIZE:  g_size = data_word[15:0];
                    hrdp_pkg::TAG_REPORT_ID: begin
                        bit_pos     = 16'(nbytes * 8);
                        g_report_id = data_word[7:0];
                        report_live = 1'b0;
                    end
                    hrdp_pkg::TAG_REPORT_COUNT: g_count = data_word[15:0];
                    default: ;
                endcase
            end
            hrdp_pkg::ITEM_LOCAL: begin
                if (item_tag == hrdp_pkg::TAG_USAGE) begin
                    l_usage = data_word[15:0];
                    if (l_usage_count < USAGE_LIMIT) begin
                        l_usage_count++;
                    end
                end else if (item_tag == hrdp_pkg::TAG_USAGE_MIN) begin
                    l_usage_min = data_word[15:0];
                end else if (item_tag == hrdp_pkg::TAG_USAGE_MAX) begin
                    l_usage_max = data_word[15:0];
                end
            end
            default: ;
        endcase
    endfunction

    // one accepted byte: assemble the item, queue what it yields
    function automatic void decode_byte(input logic [7:0] value, input logic last);
        bit          complete;
        int unsigned idx;
        hrdp_pkg::t_result done;
        complete = 1'b0;
        if (!long_seen) begin
            if (bytes_left == 3'd0) begin
                cur_prefix = value;
                data_word  = '0;
                if (value[7:4] == hrdp_pkg::TAG_LONG) begin
                    long_seen = 1'b1;
                end else begin
                    bytes_left = (value[1:0] == 2'd3) ? 3'd4 : {1'b0, value[1:0]};
                    complete   = (bytes_left == 3'd0);
                end
            end else begin
                idx        = ((cur_prefix[1:0] == 2'd3) ? 4 : cur_prefix[1:0]) - bytes_left;
                data_word  = data_word | (32'(value) << (8 * (idx % 4)));
                bytes_left = bytes_left - 3'd1;
                complete   = (bytes_left == 3'd0);
            end
            if (complete) begin
                run_decoded_item();
            end
        end
        if (last) begin
            done = '0;
            done.result_kind = (complete && !long_seen) ? hrdp_pkg::KIND_DONE_OK
                                                        : hrdp_pkg::KIND_DONE_ERR;
            awaited_results.push_back(done);
            reset_parse();
        end
    endfunction

    // ---------------- result side ----------------
    function automatic string show(input hrdp_pkg::t_result r);
        string front;
        front = $sformatf("kind=%0d start=%0d size=%0d count=%0d id=%0d app=%0d ",
                          r.result_kind, r.start_bit, r.field_size, r.field_count,
                          r.report_ident, r.app_usage);
        return {front, $sformatf("umin=%h umax=%h ucnt=%0d lmin=%h lmax=%h new=%0d",
                                 r.usage_low, r.usage_high, r.usage_count,
                                 r.logical_low, r.logical_high, r.new_report)};
    endfunction

    function automatic void check_result();
        hrdp_pkg::t_result got;
        hrdp_pkg::t_result want;
        got.result_kind  = res_if.result_kind;
        got.start_bit    = res_if.start_bit;
        got.field_size   = res_if.field_size;
        got.field_count  = res_if.field_count;
        got.report_ident = res_if.report_ident;
        got.app_usage    = res_if.app_usage;
        got.usage_low    = res_if.usage_low;
        got.usage_high   = res_if.usage_high;
        got.usage_count  = res_if.usage_count;
        got.logical_low  = res_if.logical_low;
        got.logical_high = res_if.logical_high;
        got.new_report   = res_if.new_report;
        if (awaited_results.size() == 0) begin
            bad_results++;
            if (bad_results <= 10) begin
                $display("tb: unexpected result beat: %s", show(got));
            end
            return;
        end
        want = awaited_results.pop_front();
        if (got.result_kind !== want.result_kind || got.start_bit !== want.start_bit ||
            got.field_size !== want.field_size || got.field_count !== want.field_count ||
            got.report_ident !== want.report_ident || got.app_usage !== want.app_usage ||
            got.usage_low !== want.usage_low || got.usage_high !== want.usage_high ||
            got.usage_count !== want.usage_count || got.logical_low !== want.logical_low ||
            got.logical_high !== want.logical_high || got.new_report !== want.new_report) begin
            bad_results++;
            if (bad_results <= 10) begin
                $display("tb: mismatch, expected %s", show(want));
                $display("tb:            actual %s", show(got));
            end
        end
    endfunction

    // sink with random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                check_result();
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic send_byte(input logic [7:0] value, input logic last);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            desc_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        desc_if.valid     <= 1'b1;
        desc_if.desc_byte <= value;
        desc_if.last_byte <= last;
        do @(posedge i_clk); while (!desc_if.ready);
        decode_byte(value, last);
    endtask

    // hold the sender off until every queued result has been seen
    task automatic wait_drain();
        desc_if.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    task automatic send_descriptor(input int pause_at);
        for (int i = 0; i < desc_q.size(); i++) begin
            if (i == pause_at) begin
                wait_drain();
            end
            send_byte(desc_q[i], i == desc_q.size() - 1);
        end
    endtask

    function automatic void put_item(input logic [1:0] item_type, input logic [3:0] tag,
                                     input logic [31:0] value, input int nbytes);
        logic [1:0] code;
        code = (nbytes == 4) ? 2'd3 : 2'(nbytes);
        desc_q.push_back({tag, item_type, code});
        for (int i = 0; i < nbytes; i++) begin
            desc_q.push_back(value[8*i +: 8]);
        end
    endfunction

    // usually the shortest length that holds the value, now and then any length
    function automatic int pick_len(input logic [31:0] value);
        int n;
        if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(0, 3);
            return (n == 3) ? 4 : n;
        end
        if (value == 0) return $urandom_range(0, 1);
        if (value < 32'h100) return 1;
        if (value < 32'h10000) return 2;
        return 4;
    endfunction

    function automatic void put_rand(input logic [1:0] item_type, input logic [3:0] tag,
                                     input logic [31:0] value);
        put_item(item_type, tag, value, pick_len(value));
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15);
            1: return $urandom_range(0, 255);
            2: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic void put_fields();
        int n_usages;
        logic [3:0] tag;
        case ($urandom_range(0, 9))
            0, 1: begin
                put_rand(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_LOGICAL_MIN,
                         $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1)));
                put_rand(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_LOGICAL_MAX, rand_value());
            end
            2: put_rand(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_REPORT_SIZE,
                        $urandom_range(0, 2) ? 32'($urandom_range(1, 8)) : rand_value());
            3: put_rand(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_REPORT_COUNT,
                        $urandom_range(0, 2) ? 32'($urandom_range(1, 8)) : rand_value());
            4: put_rand(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_REPORT_ID, rand_value());
            5: begin
                put_rand(hrdp_pkg::ITEM_LOCAL, hrdp_pkg::TAG_USAGE_MIN, rand_value());
                if ($urandom_range(0, 3) != 0) begin
                    put_rand(hrdp_pkg::ITEM_LOCAL, hrdp_pkg::TAG_USAGE_MAX, rand_value());
                end
            end
            6: begin
                // occasionally run past the usage limit
                n_usages = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 20)
                                                       : $urandom_range(1, 3);
                repeat (n_usages) put_rand(hrdp_pkg::ITEM_LOCAL, hrdp_pkg::TAG_USAGE,
                                           rand_value());
            end
            7: begin
                tag = $urandom_range(0, 1) ? TAG_OUTPUT : TAG_FEATURE;
                put_rand(hrdp_pkg::ITEM_MAIN, tag, rand_value());
            end
            8: begin
                put_rand(hrdp_pkg::ITEM_MAIN, hrdp_pkg::TAG_COLLECTION, COLL_PHYSICAL);
                put_rand(hrdp_pkg::ITEM_MAIN, hrdp_pkg::TAG_INPUT, rand_value());
                put_rand(hrdp_pkg::ITEM_MAIN, hrdp_pkg::TAG_END_COLL, 0);
            end
            default: begin
                // assorted items of any type and tag, never a long item
                tag = 4'($urandom_range(0, 14));
                put_rand(2'($urandom_range(0, 3)), tag, rand_value());
            end
        endcase
    endfunction

    function automatic void build_descriptor();
        logic [31:0] app;
        int          cut;
        desc_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 24)) desc_q.push_back(8'($urandom));
            return;
        end
        case ($urandom_range(0, 5))
            0: app = hrdp_pkg::USAGE_MOUSE;
            1: app = hrdp_pkg::USAGE_JOYSTICK;
            2: app = hrdp_pkg::USAGE_GAMEPAD;
            3: app = hrdp_pkg::USAGE_KEYBOARD;
            default: app = rand_value();
        endcase
        put_rand(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_USAGE_PAGE,
                 $urandom_range(0, 7) ? 32'(hrdp_pkg::PAGE_GENERIC_DESKTOP) : rand_value());
        put_rand(hrdp_pkg::ITEM_LOCAL, hrdp_pkg::TAG_USAGE, app);
        put_rand(hrdp_pkg::ITEM_MAIN, hrdp_pkg::TAG_COLLECTION,
                 $urandom_range(0, 7) ? hrdp_pkg::COLL_APPLICATION
                                      : 32'($urandom_range(0, 3)));
        if ($urandom_range(0, 1)) begin
            put_rand(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_REPORT_ID, $urandom_range(1, 255));
        end
        repeat ($urandom_range(1, 5)) begin
            repeat ($urandom_range(0, 3)) put_fields();
            put_rand(hrdp_pkg::ITEM_MAIN, hrdp_pkg::TAG_INPUT,
                     $urandom_range(0, 2) ? INPUT_VARIABLE : 32'($urandom_range(0, 255)));
        end
        // extra end items let the depth wrap below zero
        repeat ($urandom_range(0, 5) == 0 ? 2 : 1) begin
            put_rand(hrdp_pkg::ITEM_MAIN, hrdp_pkg::TAG_END_COLL, 0);
        end
        case ($urandom_range(0, 19))
            0, 1: begin
                cut = $urandom_range(1, desc_q.size() - 1);
                while (desc_q.size() > cut) void'(desc_q.pop_back());
            end
            2: desc_q.insert($urandom_range(0, desc_q.size() - 1),
                             {hrdp_pkg::TAG_LONG, 4'($urandom)});
            default: ;
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_mouse_report();
        desc_q.delete();
        put_item(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_USAGE_PAGE,
                 32'(hrdp_pkg::PAGE_GENERIC_DESKTOP), 1);
        put_item(hrdp_pkg::ITEM_LOCAL, hrdp_pkg::TAG_USAGE, 32'(hrdp_pkg::USAGE_MOUSE), 1);
        put_item(hrdp_pkg::ITEM_MAIN, hrdp_pkg::TAG_COLLECTION, hrdp_pkg::COLL_APPLICATION, 1);
        put_item(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_REPORT_ID, 32'd7, 1);
        put_item(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_REPORT_SIZE, 32'd1, 1);
        put_item(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_REPORT_COUNT, 32'd3, 1);
        put_item(hrdp_pkg::ITEM_LOCAL, hrdp_pkg::TAG_USAGE_MIN, 32'd1, 1);
        put_item(hrdp_pkg::ITEM_LOCAL, hrdp_pkg::TAG_USAGE_MAX, 32'd3, 1);
        put_item(hrdp_pkg::ITEM_MAIN, hrdp_pkg::TAG_INPUT, INPUT_VARIABLE, 1);
        put_item(hrdp_pkg::ITEM_LOCAL, hrdp_pkg::TAG_USAGE, 32'h30, 1);
        put_item(hrdp_pkg::ITEM_MAIN, hrdp_pkg::TAG_INPUT, INPUT_VARIABLE | INPUT_RELATIVE, 1);
        // negative minimum makes the maximum signed as well
        put_item(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_LOGICAL_MIN, 32'hFFFF_FF80, 1);
        put_item(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_LOGICAL_MAX, 32'h0000_FFFF, 2);
        put_item(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_REPORT_SIZE, 32'h5678, 2);
        put_item(hrdp_pkg::ITEM_MAIN, hrdp_pkg::TAG_INPUT, 32'h0, 1);
        // segment lands on the final byte, done follows it
        put_item(hrdp_pkg::ITEM_MAIN, hrdp_pkg::TAG_INPUT, INPUT_VARIABLE, 1);
        send_descriptor(-1);
    endtask

    task automatic test_error_endings();
        desc_q.delete();
        desc_q.push_back({hrdp_pkg::TAG_LONG, 4'hF});
        send_descriptor(-1);
        desc_q.delete();
        desc_q.push_back({hrdp_pkg::TAG_LONG, 4'h2});
        desc_q.push_back(8'h00);
        desc_q.push_back(8'hFF);
        send_descriptor(-1);
        desc_q.delete();
        put_item(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_REPORT_COUNT, 32'h8001_0002, 4);
        put_item(hrdp_pkg::ITEM_GLOBAL, hrdp_pkg::TAG_LOGICAL_MAX, 32'h1234, 2);
        void'(desc_q.pop_back());
        send_descriptor(-1);
        desc_q.delete();
        put_item(hrdp_pkg::ITEM_MAIN, 4'd0, 32'h0, 0);
        send_descriptor(-1);
    endtask

    task automatic test_random_descriptors();
        int sent;
        sent = 0;
        while (sent < 950) begin
            sender_idles = $urandom_range(0, 3) != 0;
            sink_stalls  = $urandom_range(0, 3) != 0;
            build_descriptor();
            sent += desc_q.size();
            send_descriptor(-1);
            if ($urandom_range(0, 9) == 0) wait_drain();
        end
    endtask

    task automatic test_midstream_drain();
        sender_idles = 1'b1;
        sink_stalls  = 1'b1;
        repeat (3) begin
            build_descriptor();
            send_descriptor(desc_q.size() / 2);
        end
    endtask

    task automatic test_back_to_back();
        int sent;
        sent = 0;
        sender_idles = 1'b0;
        sink_stalls  = 1'b0;
        while (sent < 120) begin
            build_descriptor();
            sent += desc_q.size();
            send_descriptor(-1);
        end
    endtask

    initial begin
        desc_if.valid     = 1'b0;
        desc_if.desc_byte = '0;
        desc_if.last_byte = 1'b0;
        i_rst_n           = 1'b0;
        reset_parse();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_mouse_report();
        test_error_endings();
        test_random_descriptors();
        test_midstream_drain();
        test_back_to_back();

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (bad_results == 0 && awaited_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
